[hw/rtl/tgd_pkg.sv]
// Shared types and constants for the touch gesture detector.
// Used by tgd_core, tgd_out_fifo and touch_gesture_detector; depends on nothing.
package tgd_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned FifoDepth     = 4;
   localparam int unsigned FifoPtrWidth  = $clog2(FifoDepth);
   localparam int unsigned FifoCntWidth  = $clog2(FifoDepth + 1);

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_THRESHOLD     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RISING        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TAP_WINDOW    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_GAP_WINDOW    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_PRESS    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_REPEAT        = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE      = 3'd6;

   // Register values after reset.
   localparam logic [15:0] RST_THRESHOLD  = 16'd0;
   localparam logic        RST_RISING     = 1'b1;
   localparam logic [31:0] RST_TAP_WINDOW = 32'd300;
   localparam logic [31:0] RST_GAP_WINDOW = 32'd300;
   localparam logic [31:0] RST_LONG_PRESS = 32'd800;
   localparam logic [31:0] RST_REPEAT     = 32'd200;
   localparam logic [7:0]  RST_DEBOUNCE   = 8'd1;

   localparam logic [7:0]  TapMax         = 8'd255;

   typedef enum logic [2:0] {
      EV_SINGLE = 3'd0,
      EV_DOUBLE = 3'd1,
      EV_MULTI  = 3'd2,
      EV_LONG   = 3'd3,
      EV_REPEAT = 3'd4
   } event_type;

   typedef struct packed {
      logic [15:0] threshold;
      logic        rising;
      logic [31:0] tap_window_ms;
      logic [31:0] gap_window_ms;
      logic [31:0] long_press_ms;
      logic [31:0] repeat_interval_ms;
      logic [7:0]  debounce_limit;
   } cfg_type;

   typedef struct packed {
      event_type   event_code;
      logic [7:0]  tap_total;
      logic        last;
   } result_type;

endpackage

[hw/rtl/tgd_core.sv]
// Debounce and gesture state for the touch gesture detector.
// Depends on tgd_pkg; instantiated by touch_gesture_detector.
module tgd_core
   import tgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        fire,
   input  logic [15:0] sample,
   input  logic [31:0] now_ms,
   output logic [1:0]  res_count,
   output result_type  res0,
   output result_type  res1
);

   logic        stable_touch_ff, stable_touch_in;
   logic [7:0]  mismatch_count_ff, mismatch_count_in;
   logic        held_ff, held_in;
   logic [31:0] press_time_ff, press_time_in;
   logic        long_done_ff, long_done_in;
   logic [31:0] last_repeat_time_ff, last_repeat_time_in;
   logic [7:0]  pending_taps_ff, pending_taps_in;
   logic [31:0] release_time_ff, release_time_in;

   logic [7:0]  limit;
   logic        raw;
   logic [7:0]  mismatch_inc;
   logic [31:0] since_press, since_repeat, since_release;
   logic        long_hit, rep_hit, tap_hit;
   event_type   tap_code;

   always_comb begin
      limit        = (cfg.debounce_limit == 8'd0) ? 8'd1 : cfg.debounce_limit;
      raw          = cfg.rising ? (sample > cfg.threshold) : (sample < cfg.threshold);
      mismatch_inc = mismatch_count_ff + 8'd1;

      stable_touch_in   = stable_touch_ff;
      mismatch_count_in = 8'd0;
      if (raw != stable_touch_ff) begin
         if (mismatch_inc >= limit) begin
            stable_touch_in = raw;
         end else begin
            mismatch_count_in = mismatch_inc;
         end
      end

      since_press   = now_ms - press_time_ff;
      since_repeat  = now_ms - last_repeat_time_ff;
      since_release = now_ms - release_time_ff;

      held_in             = held_ff;
      press_time_in       = press_time_ff;
      long_done_in        = long_done_ff;
      last_repeat_time_in = last_repeat_time_ff;
      pending_taps_in     = pending_taps_ff;
      release_time_in     = release_time_ff;
      long_hit            = 1'b0;
      rep_hit             = 1'b0;
      tap_hit             = 1'b0;

      if (stable_touch_in && !held_ff) begin
         held_in             = 1'b1;
         press_time_in       = now_ms;
         long_done_in        = 1'b0;
         last_repeat_time_in = now_ms;
      end else if (stable_touch_in && held_ff) begin
         long_hit = !long_done_ff && (since_press >= cfg.long_press_ms);
         // Repeat may fire in the same step as the long press.
         rep_hit  = (long_done_ff || long_hit) && (since_repeat >= cfg.repeat_interval_ms);
         if (long_hit) begin
            long_done_in    = 1'b1;
            pending_taps_in = 8'd0;
         end
         if (rep_hit) begin
            last_repeat_time_in = now_ms;
         end
      end else if (!stable_touch_in && held_ff) begin
         held_in = 1'b0;
         if (!long_done_ff && (since_press < cfg.tap_window_ms)) begin
            if (pending_taps_ff != TapMax) begin
               pending_taps_in = pending_taps_ff + 8'd1;
            end
            release_time_in = now_ms;
         end
      end else begin
         tap_hit = (pending_taps_ff != 8'd0) && (since_release >= cfg.gap_window_ms);
         if (tap_hit) begin
            pending_taps_in = 8'd0;
         end
      end

      if (pending_taps_ff == 8'd1) begin
         tap_code = EV_SINGLE;
      end else if (pending_taps_ff == 8'd2) begin
         tap_code = EV_DOUBLE;
      end else begin
         tap_code = EV_MULTI;
      end

      res_count = {1'b0, long_hit} + {1'b0, rep_hit} + {1'b0, tap_hit};

      res0.event_code = tap_hit ? tap_code : (long_hit ? EV_LONG : EV_REPEAT);
      res0.tap_total  = (tap_hit && tap_code == EV_MULTI) ? pending_taps_ff : 8'd0;
      res0.last       = !(long_hit && rep_hit);

      res1.event_code = EV_REPEAT;
      res1.tap_total  = 8'd0;
      res1.last       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_touch_ff     <= 1'b0;
         mismatch_count_ff   <= 8'd0;
         held_ff             <= 1'b0;
         press_time_ff       <= 32'd0;
         long_done_ff        <= 1'b0;
         last_repeat_time_ff <= 32'd0;
         pending_taps_ff     <= 8'd0;
         release_time_ff     <= 32'd0;
      end else if (fire) begin
         stable_touch_ff     <= stable_touch_in;
         mismatch_count_ff   <= mismatch_count_in;
         held_ff             <= held_in;
         press_time_ff       <= press_time_in;
         long_done_ff        <= long_done_in;
         last_repeat_time_ff <= last_repeat_time_in;
         pending_taps_ff     <= pending_taps_in;
         release_time_ff     <= release_time_in;
      end
   end

endmodule

[hw/rtl/tgd_out_fifo.sv]
// Small result queue for the touch gesture detector: takes up to two results
// a cycle and hands out one while rsp_stall is low. Depends on tgd_pkg.
module tgd_out_fifo
   import tgd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  result_type              push0,
   input  result_type              push1,
   output logic                    room_for_two,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output result_type              head
);

   result_type               entry_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FifoCntWidth-1:0]  count_ff, count_in;
   logic [FifoPtrWidth-1:0]  wr_ptr_next;
   logic                     pop;

   always_comb begin
      pop          = (count_ff != '0) && !rsp_stall;
      wr_ptr_next  = wr_ptr_ff + FifoPtrWidth'(1);
      wr_ptr_in    = wr_ptr_ff + FifoPtrWidth'(push_count);
      rd_ptr_in    = rd_ptr_ff + FifoPtrWidth'(pop);
      count_in     = count_ff + FifoCntWidth'(push_count) - FifoCntWidth'(pop);
      room_for_two = count_ff <= FifoCntWidth'(FifoDepth - 2);
      rsp_valid    = count_ff != '0;
      head         = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push1;
      end
   end

endmodule

[hw/rtl/touch_gesture_detector.sv]
// Touch gesture detector, top level: one sample with its millisecond time
// stamp per request; it reports taps, long presses and repeats. A request is
// registered, worked by tgd_core, and its zero to two results go into a
// four-entry queue, so the block takes one request every cycle for as long
// as that queue holds two or fewer results; a result can appear once its
// request has passed the input register and been written into the queue.
// A request with two results (long press and repeat) fills two places, and
// the queue drains one per cycle while the result side does not stall, which
// sets the sustained rate. Depends on tgd_pkg, tgd_core and tgd_out_fifo.
module touch_gesture_detector
   import tgd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [15:0]              req_sample,
   input  logic [31:0]              req_now_ms,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_event_code,
   output logic [7:0]               rsp_tap_total,
   output logic                     rsp_last
);

   cfg_type     cfg_ff;
   logic        in_valid_ff, in_valid_in;
   logic [15:0] sample_ff;
   logic [31:0] now_ms_ff;
   logic        fire, room_for_two, accept;
   logic [1:0]  res_count, push_count;
   result_type  res0, res1, head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold          <= RST_THRESHOLD;
         cfg_ff.rising             <= RST_RISING;
         cfg_ff.tap_window_ms      <= RST_TAP_WINDOW;
         cfg_ff.gap_window_ms      <= RST_GAP_WINDOW;
         cfg_ff.long_press_ms      <= RST_LONG_PRESS;
         cfg_ff.repeat_interval_ms <= RST_REPEAT;
         cfg_ff.debounce_limit     <= RST_DEBOUNCE;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_THRESHOLD:  cfg_ff.threshold          <= csr_wdata[15:0];
            CSR_RISING:     cfg_ff.rising             <= csr_wdata[0];
            CSR_TAP_WINDOW: cfg_ff.tap_window_ms      <= csr_wdata;
            CSR_GAP_WINDOW: cfg_ff.gap_window_ms      <= csr_wdata;
            CSR_LONG_PRESS: cfg_ff.long_press_ms      <= csr_wdata;
            CSR_REPEAT:     cfg_ff.repeat_interval_ms <= csr_wdata;
            CSR_DEBOUNCE:   cfg_ff.debounce_limit     <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // The held request is worked when the queue can take both possible results.
   always_comb begin
      fire        = in_valid_ff && room_for_two;
      req_stall   = in_valid_ff && !room_for_two;
      accept      = req_valid && !req_stall;
      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      push_count  = fire ? res_count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         now_ms_ff <= req_now_ms;
      end
   end

   tgd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (fire),
      .sample    (sample_ff),
      .now_ms    (now_ms_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   tgd_out_fifo u_out_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (res0),
      .push1        (res1),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .head         (head)
   );

   assign rsp_event_code = head.event_code;
   assign rsp_tap_total  = head.tap_total;
   assign rsp_last       = head.last;

endmodule
